// File: hdl/ita_pkg.sv
`default_nettype none

package ita_pkg;

    // Configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_OUTPUT_RADIX    = 2'd0;
    localparam cfg_index_t REG_HEX_UPPERCASE   = 2'd1;
    localparam cfg_index_t REG_HEX_DIGIT_COUNT = 2'd2;

    localparam int CFG_DATA_W = 4;

    // Radix codes
    localparam logic RADIX_DEC = 1'b0;
    localparam logic RADIX_HEX = 1'b1;

    // Hex digit count, wide enough for any supported maximum (up to 16)
    localparam int HEX_CNT_W = 5;

    // Character codes
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;

    // Wide enough for 9 * 10^19
    localparam int PROD_W = 68;

    // Classified command, front to back
    typedef struct packed {
        logic                 is_hex;
        logic                 upper;
        logic                 negative;
        logic [HEX_CNT_W-1:0] hex_count;
    } cmd_ctrl_t;

    // One output character
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    // k * 10^p, evaluated at elaboration only
    function automatic logic [PROD_W-1:0] pow10_mult(input int p, input int k);
        logic [PROD_W-1:0] r;
        r = PROD_W'(k);
        for (int i = 0; i < p; i++) begin
            r = r * PROD_W'(10);
        end
        return r;
    endfunction

    // Decimal digits needed for the largest unsigned value of w bits
    function automatic int dec_digit_count(input int w);
        logic [PROD_W-1:0] maxv;
        logic [PROD_W-1:0] pw;
        int                n;
        maxv = (PROD_W'(1) << w) - PROD_W'(1);
        pw   = PROD_W'(10);
        n    = 1;
        for (int i = 0; i < 24; i++) begin
            if (pw <= maxv) begin
                pw = pw * PROD_W'(10);
                n  = n + 1;
            end
        end
        return n;
    endfunction

    // Hex digit character
    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CHAR_ZERO + 8'(nib);
        end
        else if (upper) begin
            c = CHAR_UPPER_A + 8'(nib) - 8'd10;
        end
        else begin
            c = CHAR_LOWER_A + 8'(nib) - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ita_fifo.sv
`default_nettype none

module ita_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W:0] DEPTH_C = (PTR_W + 1)'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ita_front.sv
`default_nettype none

module ita_front #(
    parameter int VALUE_WIDTH    = 32,
    parameter int MAX_HEX_DIGITS = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration writes
    input  wire logic                         cfg_write,
    input  wire ita_pkg::cfg_index_t          cfg_index,
    input  wire logic [ita_pkg::CFG_DATA_W-1:0] cfg_data,
    // input transfer
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [VALUE_WIDTH-1:0]       number_value,
    input  wire logic                         is_signed,
    // command queue
    output logic                              cmd_push,
    input  wire logic                         cmd_full,
    output ita_pkg::cmd_ctrl_t                cmd_ctrl,
    output logic      [VALUE_WIDTH-1:0]       cmd_value
);

    import ita_pkg::*;

    localparam logic [HEX_CNT_W-1:0] MAX_CNT = HEX_CNT_W'(MAX_HEX_DIGITS);

    logic       radix_reg;
    logic       upper_reg;
    logic [3:0] count_reg;

    logic [HEX_CNT_W-1:0] count_ext;
    logic [HEX_CNT_W-1:0] count_sat;
    logic                 negative;
    logic                 drop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_DEC;
            upper_reg <= 1'b1;
            count_reg <= 4'd8;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_OUTPUT_RADIX:    radix_reg <= cfg_data[0];
                REG_HEX_UPPERCASE:   upper_reg <= cfg_data[0];
                REG_HEX_DIGIT_COUNT: count_reg <= cfg_data[3:0];
                default:             ;
            endcase
        end
    end

    // Classification: saturated hex count, sign, magnitude
    assign count_ext = HEX_CNT_W'(count_reg);
    assign count_sat = (count_ext > MAX_CNT) ? MAX_CNT : count_ext;
    assign negative  = (radix_reg == RADIX_DEC) && is_signed && number_value[VALUE_WIDTH-1];
    // a hex count of zero produces no text at all
    assign drop      = (radix_reg == RADIX_HEX) && (count_sat == '0);

    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full && !drop;

    always_comb
    begin
        cmd_ctrl.is_hex    = (radix_reg == RADIX_HEX);
        cmd_ctrl.upper     = upper_reg;
        cmd_ctrl.negative  = negative;
        cmd_ctrl.hex_count = count_sat;
        // most negative value negates to itself, which reads correctly unsigned
        cmd_value          = negative ? (~number_value + 1'b1) : number_value;
    end

endmodule

`default_nettype wire

// File: hdl/ita_back.sv
`default_nettype none

module ita_back #(
    parameter int VALUE_WIDTH    = 32,
    parameter int MAX_HEX_DIGITS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // command queue
    input  wire logic                   cmd_valid,
    input  wire ita_pkg::cmd_ctrl_t     cmd_ctrl,
    input  wire logic [VALUE_WIDTH-1:0] cmd_value,
    output logic                        cmd_pop,
    // character queue
    input  wire logic                   out_full,
    output logic                        out_push,
    output ita_pkg::char_t              out_item
);

    import ita_pkg::*;

    localparam int NUM_DEC   = dec_digit_count(VALUE_WIDTH);
    localparam int DEC_POS_W = $clog2(NUM_DEC);
    localparam int HEX_POS_W = $clog2(MAX_HEX_DIGITS);
    localparam int CNT_W     = (DEC_POS_W > HEX_POS_W) ? DEC_POS_W : HEX_POS_W;
    localparam int TAB_W     = VALUE_WIDTH + 4;
    localparam int PAD_W     = 4 * MAX_HEX_DIGITS;

    typedef logic [TAB_W-1:0] tab_word_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SIGN = 4'b0010,
        ST_DEC  = 4'b0100,
        ST_HEX  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic                 upper_reg, upper_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic                 started_reg, started_next;

    tab_word_t            mult_tab [NUM_DEC][1:9];
    logic [TAB_W:0]       diff [1:9];
    logic [DEC_POS_W-1:0] dpos;
    logic [HEX_POS_W-1:0] hpos;
    logic [3:0]           digit;
    logic [VALUE_WIDTH-1:0] remainder;
    logic [PAD_W-1:0]     hex_pad;
    logic [3:0]           nib;
    logic                 pos_zero;

    // Constant multiples k * 10^p
    for (genvar p = 0; p < NUM_DEC; p++)
    begin : g_pow
        for (genvar k = 1; k < 10; k++)
        begin : g_mult
            assign mult_tab[p][k] = tab_word_t'(pow10_mult(p, k));
        end
    end

    // Value padded to the full hex digit span; nibbles past the value are zero
    for (genvar i = 0; i < PAD_W; i++)
    begin : g_pad
        if (i < VALUE_WIDTH)
        begin : g_bit
            assign hex_pad[i] = value_reg[i];
        end
        else
        begin : g_zero
            assign hex_pad[i] = 1'b0;
        end
    end

    assign dpos     = pos_reg[DEC_POS_W-1:0];
    assign hpos     = pos_reg[HEX_POS_W-1:0];
    assign pos_zero = (pos_reg == '0);
    assign nib      = hex_pad[{hpos, 2'b00} +: 4];

    // Decimal digit at the current position: largest multiple that fits
    always_comb
    begin
        digit     = 4'd0;
        remainder = value_reg;
        for (int k = 1; k < 10; k++)
        begin
            diff[k] = {5'b00000, value_reg} - {1'b0, mult_tab[dpos][k]};
            if (!diff[k][TAB_W])
            begin
                digit     = 4'(k);
                remainder = diff[k][VALUE_WIDTH-1:0];
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        value_next   = value_reg;
        upper_next   = upper_reg;
        pos_next     = pos_reg;
        started_next = started_reg;
        cmd_pop      = 1'b0;
        out_push     = 1'b0;
        out_item.ch   = CHAR_ZERO + 8'(digit);
        out_item.last = pos_zero;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    value_next   = cmd_value;
                    upper_next   = cmd_ctrl.upper;
                    started_next = 1'b0;
                    if (cmd_ctrl.is_hex)
                    begin
                        pos_next   = CNT_W'(cmd_ctrl.hex_count - 1'b1);
                        state_next = ST_HEX;
                    end
                    else
                    begin
                        pos_next   = CNT_W'(NUM_DEC - 1);
                        state_next = cmd_ctrl.negative ? ST_SIGN : ST_DEC;
                    end
                end
            end
            ST_SIGN:
            begin
                out_item.ch   = CHAR_MINUS;
                out_item.last = 1'b0;
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (!out_full)
                begin
                    // leading zeros are skipped, the units digit always goes out
                    out_push   = (digit != 4'd0) || started_reg || pos_zero;
                    value_next = remainder;
                    if (digit != 4'd0)
                    begin
                        started_next = 1'b1;
                    end
                    if (pos_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            ST_HEX:
            begin
                out_item.ch = hex_char(nib, upper_reg);
                if (!out_full)
                begin
                    out_push = 1'b1;
                    if (pos_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            pos_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            pos_reg     <= pos_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        upper_reg <= upper_next;
    end

endmodule

`default_nettype wire

// File: hdl/integer_to_ascii_formatter.sv
// Channel   Transfer when        Payload
// input     push && !full        number_value, is_signed
// result    pop && !empty        ascii_char, last_char
// config    cfg_write            cfg_index, cfg_data
//
// Decimal output puts a minus sign first for negative numbers and visits every
// decimal position of the digit sequencer (NUM_DEC = 10 at 32 bits); hex output
// gives min(hex_digit_count, MAX_HEX_DIGITS) digits, and a zero count none.
// Reset clears the configuration to decimal, upper case, eight hex digits,
// and empties both queues. A full result queue stalls the digit sequencer;
// the two-entry command queue keeps taking numbers meanwhile until it is full.
`default_nettype none

module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH    = 32,
    parameter int MAX_HEX_DIGITS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire ita_pkg::cfg_index_t            cfg_index,
    input  wire logic [ita_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [VALUE_WIDTH-1:0]         number_value,
    input  wire logic                           is_signed,
    output logic                                empty,
    input  wire logic                           pop,
    output logic      [7:0]                     ascii_char,
    output logic                                last_char
);

    import ita_pkg::*;

    localparam int CMD_W = $bits(cmd_ctrl_t) + VALUE_WIDTH;

    logic                   cmd_push, cmd_full, cmd_empty, cmd_pop;
    cmd_ctrl_t              front_ctrl, back_ctrl;
    logic [VALUE_WIDTH-1:0] front_value, back_value;
    logic [CMD_W-1:0]       cmd_rd_data;
    logic                   out_push, out_full;
    char_t                  out_wr_item, out_rd_item;

    // Front: configuration and classification
    ita_front #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .number_value (number_value),
        .is_signed    (is_signed),
        .cmd_push     (cmd_push),
        .cmd_full     (cmd_full),
        .cmd_ctrl     (front_ctrl),
        .cmd_value    (front_value)
    );

    // Command queue between front and back
    ita_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data ({front_ctrl, front_value}),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd_data),
        .empty   (cmd_empty)
    );

    assign {back_ctrl, back_value} = cmd_rd_data;

    // Back: digit sequencer
    ita_back #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd_ctrl  (back_ctrl),
        .cmd_value (back_value),
        .cmd_pop   (cmd_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (out_wr_item)
    );

    // Result queue
    ita_fifo #(
        .WIDTH ($bits(char_t)),
        .DEPTH (2)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_wr_item),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_rd_item),
        .empty   (empty)
    );

    assign ascii_char = out_rd_item.ch;
    assign last_char  = out_rd_item.last;

endmodule

`default_nettype wire
